### design/klc_pkg.sv
// Shared types and operation codes for the keyed LRU cache.
package klc_pkg;

	typedef enum logic [2:0] {
		OP_LOOKUP     = 3'd0,
		OP_COMPILE    = 3'd1,
		OP_INVALIDATE = 3'd2,
		OP_INVAL_ALL  = 3'd3,
		OP_EVICT      = 3'd4
	} op_t;

	// One stored table entry.
	typedef struct packed {
		logic [63:0] code_hash;
		logic [63:0] state_hash;
		logic [2:0]  stage;
		logic [47:0] last_use;
		logic [31:0] payload;
		logic        usable;
		logic [31:0] hits;
	} entry_t;

	localparam int unsigned CAP_W     = 9;
	localparam logic [8:0]  CAP_RESET = 9'd256;

endpackage

### design/klc_ifs.sv
// Channel interfaces for the keyed LRU cache.
interface klc_in_if;
	logic        valid;
	logic        ready;
	logic [2:0]  operation;
	logic [63:0] code_hash;
	logic [63:0] state_hash;
	logic [2:0]  stage_code;
	logic [47:0] now_time;
	logic [31:0] payload_handle;
	logic        payload_present;
	logic [47:0] age_limit;
	modport source(output valid, operation, code_hash, state_hash, stage_code, now_time,
		payload_handle, payload_present, age_limit, input ready);
	modport sink(input valid, operation, code_hash, state_hash, stage_code, now_time,
		payload_handle, payload_present, age_limit, output ready);
endinterface

interface klc_out_if;
	logic        valid;
	logic        ready;
	logic        found;
	logic [31:0] entry_payload;
	logic        entry_usable;
	logic [31:0] entry_hits;
	logic [8:0]  removed_count;
	logic        lru_replaced;
	logic [8:0]  occupancy;
	logic [31:0] hit_total;
	logic [31:0] miss_total;
	logic [31:0] eviction_total;
	logic [31:0] insert_total;
	modport source(output valid, found, entry_payload, entry_usable, entry_hits,
		removed_count, lru_replaced, occupancy, hit_total, miss_total, eviction_total,
		insert_total, input ready);
	modport sink(input valid, found, entry_payload, entry_usable, entry_hits,
		removed_count, lru_replaced, occupancy, hit_total, miss_total, eviction_total,
		insert_total, output ready);
endinterface

interface klc_cfg_if;
	logic       valid;
	logic       ready;
	logic [8:0] capacity_limit;
	modport source(output valid, capacity_limit, input ready);
	modport sink(input valid, capacity_limit, output ready);
endinterface

### design/keyed_lru_cache_with_age_eviction.sv
// Keyed LRU cache: one item is accepted when in_ch.ready is high; lookup,
// compile, invalidate and evict-stale make one pass over the entry memory at
// one read a cycle, while invalidate-all and unused codes go straight to the
// finishing step. The result waits in an output register, and the next
// item is taken while it waits. Valid bits sit in flip-flops and clear at once.
module keyed_lru_cache_with_age_eviction
	import klc_pkg::*;
#(
	parameter int unsigned SLOT_COUNT = 256
) (
	input  logic       clk,
	input  logic       arst_n,
	klc_in_if.sink     in_ch,
	klc_out_if.source  out_ch,
	klc_cfg_if.sink    cfg_ch
);

	localparam int unsigned IDX_W = $clog2(SLOT_COUNT);
	localparam int unsigned CNT_W = $clog2(SLOT_COUNT + 1);
	localparam int unsigned LW    = (CNT_W > CAP_W) ? CNT_W : CAP_W;

	localparam logic [1:0] S_IDLE   = 2'd0;
	localparam logic [1:0] S_SCAN   = 2'd1;
	localparam logic [1:0] S_FINISH = 2'd2;

	logic [1:0]            state_q;
	logic [CNT_W-1:0]      addr_q;
	logic                  rd_en;
	logic                  rd_vld_s1;
	logic [IDX_W-1:0]      idx_s1;
	entry_t                rd_data;
	logic                  wr_en;
	logic [IDX_W-1:0]      wr_addr;
	entry_t                wr_data;

	logic [SLOT_COUNT-1:0] valid_q;
	logic [CNT_W-1:0]      occ_q;
	logic [CAP_W-1:0]      cap_q;
	logic [31:0]           hit_tot_q, miss_tot_q, evict_tot_q, ins_tot_q;

	// Latched item.
	logic [2:0]            op_q;
	logic [63:0]           code_q, st_hash_q;
	logic [2:0]            stage_q;
	logic [47:0]           now_q, cutoff_q;
	logic [31:0]           pay_q;
	logic                  pres_q;

	// Scan results.
	logic                  hit_any_q;
	logic [IDX_W-1:0]      hit_idx_q;
	entry_t                hit_ent_q;
	logic                  lru_any_q;
	logic [IDX_W-1:0]      lru_idx_q;
	logic [47:0]           lru_time_q;
	logic                  free_any_q;
	logic [IDX_W-1:0]      free_idx_q;
	logic [CNT_W-1:0]      removed_q;

	// Output register.
	logic                  out_vld_q;
	logic                  found_q, usable_o_q, replaced_o_q;
	logic [31:0]           pay_o_q, hits_o_q;
	logic [CAP_W-1:0]      removed_o_q;

	logic                  slot_v;
	logic                  key_eq;
	logic                  fin;
	logic [LW-1:0]         lim;
	logic                  need_repl;
	logic                  do_repl;
	logic                  can_ins;
	logic [IDX_W-1:0]      ins_idx;
	logic                  is_cmp_miss;

	assign in_ch.ready  = (state_q == S_IDLE);
	assign cfg_ch.ready = 1'b1;
	assign rd_en        = (state_q == S_SCAN) && (addr_q != CNT_W'(SLOT_COUNT));
	assign fin          = (state_q == S_FINISH) && (!out_vld_q || out_ch.ready);

	klc_slot_ram #(.SLOT_COUNT(SLOT_COUNT), .IDX_W(IDX_W)) u_ram (
		.clk     (clk),
		.rd_en   (rd_en),
		.rd_addr (addr_q[IDX_W-1:0]),
		.rd_data (rd_data),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data)
	);

	// Per-slot checks on the entry that has just been read.
	assign slot_v = valid_q[idx_s1];
	assign key_eq = slot_v && (rd_data.code_hash == code_q) &&
		(rd_data.state_hash == st_hash_q) && (rd_data.stage == stage_q);

	// Replacement and insert slot choice.
	always_comb begin
		lim = LW'(cap_q);
		if (cap_q == '0) begin
			lim = LW'(1);
		end else if (LW'(cap_q) > LW'(SLOT_COUNT)) begin
			lim = LW'(SLOT_COUNT);
		end
		is_cmp_miss = (op_q == OP_COMPILE) && !hit_any_q;
		need_repl   = LW'(occ_q) >= lim;
		do_repl     = is_cmp_miss && need_repl && lru_any_q;
		can_ins     = free_any_q || do_repl;
		ins_idx     = free_idx_q;
		if (do_repl && (!free_any_q || (lru_idx_q < free_idx_q))) begin
			ins_idx = lru_idx_q;
		end
	end

	// Write-back of a hit or of a new entry.
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = hit_idx_q;
		wr_data = hit_ent_q;
		if (fin && hit_any_q && (op_q == OP_LOOKUP || op_q == OP_COMPILE)) begin
			wr_en            = 1'b1;
			wr_data.hits     = hit_ent_q.hits + 32'd1;
			wr_data.last_use = now_q;
		end else if (fin && is_cmp_miss && can_ins) begin
			wr_en              = 1'b1;
			wr_addr            = ins_idx;
			wr_data.code_hash  = code_q;
			wr_data.state_hash = st_hash_q;
			wr_data.stage      = stage_q;
			wr_data.last_use   = now_q;
			wr_data.payload    = pay_q;
			wr_data.usable     = pres_q;
			wr_data.hits       = '0;
		end
	end

	// Item latch.
	always_ff @(posedge clk) begin
		if (in_ch.valid && in_ch.ready) begin
			op_q      <= in_ch.operation;
			code_q    <= in_ch.code_hash;
			st_hash_q <= in_ch.state_hash;
			stage_q   <= in_ch.stage_code;
			now_q     <= in_ch.now_time;
			pay_q     <= in_ch.payload_handle;
			pres_q    <= in_ch.payload_present;
			cutoff_q  <= (in_ch.now_time > in_ch.age_limit) ?
				in_ch.now_time - in_ch.age_limit : '0;
		end
	end

	// Scan data registers.
	always_ff @(posedge clk) begin
		idx_s1 <= addr_q[IDX_W-1:0];
		if (rd_vld_s1) begin
			if (key_eq && !hit_any_q) begin
				hit_idx_q <= idx_s1;
				hit_ent_q <= rd_data;
			end
			if (slot_v && (!lru_any_q || rd_data.last_use < lru_time_q)) begin
				lru_idx_q  <= idx_s1;
				lru_time_q <= rd_data.last_use;
			end
			if (!slot_v && !free_any_q) begin
				free_idx_q <= idx_s1;
			end
		end
	end

	// Sequencer, table state and counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			addr_q       <= '0;
			rd_vld_s1    <= 1'b0;
			valid_q      <= '0;
			occ_q        <= '0;
			cap_q        <= CAP_RESET;
			hit_tot_q    <= '0;
			miss_tot_q   <= '0;
			evict_tot_q  <= '0;
			ins_tot_q    <= '0;
			hit_any_q    <= 1'b0;
			lru_any_q    <= 1'b0;
			free_any_q   <= 1'b0;
			removed_q    <= '0;
			out_vld_q    <= 1'b0;
			found_q      <= 1'b0;
			usable_o_q   <= 1'b0;
			replaced_o_q <= 1'b0;
			pay_o_q      <= '0;
			hits_o_q     <= '0;
			removed_o_q  <= '0;
		end else begin
			rd_vld_s1 <= rd_en;
			if (cfg_ch.valid && cfg_ch.ready) begin
				cap_q <= cfg_ch.capacity_limit;
			end
			if (out_vld_q && out_ch.ready) begin
				out_vld_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_ch.valid) begin
						addr_q     <= '0;
						hit_any_q  <= 1'b0;
						lru_any_q  <= 1'b0;
						free_any_q <= 1'b0;
						removed_q  <= '0;
						if (in_ch.operation == OP_LOOKUP || in_ch.operation == OP_COMPILE ||
							in_ch.operation == OP_INVALIDATE || in_ch.operation == OP_EVICT) begin
							state_q <= S_SCAN;
						end else begin
							state_q <= S_FINISH;
						end
					end
				end
				S_SCAN: begin
					if (rd_en) begin
						addr_q <= addr_q + CNT_W'(1);
					end
					if (rd_vld_s1) begin
						if (key_eq) begin
							hit_any_q <= 1'b1;
						end
						if (slot_v) begin
							lru_any_q <= 1'b1;
						end else begin
							free_any_q <= 1'b1;
						end
						// Stale entries are dropped as they are read; the entry count
						// follows at the finishing step so that a waiting result keeps it.
						if (op_q == OP_EVICT && slot_v && rd_data.last_use < cutoff_q) begin
							valid_q[idx_s1] <= 1'b0;
							removed_q       <= removed_q + CNT_W'(1);
						end
						if (!rd_en) begin
							state_q <= S_FINISH;
						end
					end
				end
				S_FINISH: begin
					if (fin) begin
						state_q      <= S_IDLE;
						out_vld_q    <= 1'b1;
						found_q      <= 1'b0;
						pay_o_q      <= '0;
						usable_o_q   <= 1'b0;
						hits_o_q     <= '0;
						removed_o_q  <= '0;
						replaced_o_q <= 1'b0;
						priority case (1'b1)
							(op_q == OP_LOOKUP || op_q == OP_COMPILE) && hit_any_q: begin
								hit_tot_q  <= hit_tot_q + 32'd1;
								found_q    <= 1'b1;
								pay_o_q    <= hit_ent_q.payload;
								usable_o_q <= hit_ent_q.usable;
								hits_o_q   <= hit_ent_q.hits + 32'd1;
							end
							op_q == OP_LOOKUP: begin
								miss_tot_q <= miss_tot_q + 32'd1;
							end
							op_q == OP_COMPILE: begin
								miss_tot_q   <= miss_tot_q + 32'd1;
								ins_tot_q    <= ins_tot_q + 32'd1;
								pay_o_q      <= pay_q;
								usable_o_q   <= pres_q;
								replaced_o_q <= do_repl;
								if (do_repl) begin
									evict_tot_q        <= evict_tot_q + 32'd1;
									valid_q[lru_idx_q] <= 1'b0;
								end
								if (can_ins) begin
									valid_q[ins_idx] <= 1'b1;
								end
								occ_q <= occ_q - CNT_W'(do_repl) + CNT_W'(can_ins);
							end
							op_q == OP_INVALIDATE: begin
								if (hit_any_q) begin
									found_q            <= 1'b1;
									valid_q[hit_idx_q] <= 1'b0;
									occ_q              <= occ_q - CNT_W'(1);
								end
							end
							op_q == OP_INVAL_ALL: begin
								removed_o_q <= CAP_W'(occ_q);
								valid_q     <= '0;
								occ_q       <= '0;
							end
							op_q == OP_EVICT: begin
								removed_o_q <= CAP_W'(removed_q);
								evict_tot_q <= evict_tot_q + 32'(removed_q);
								occ_q       <= occ_q - removed_q;
							end
							default: begin
							end
						endcase
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Result channel.
	assign out_ch.valid          = out_vld_q;
	assign out_ch.found          = found_q;
	assign out_ch.entry_payload  = pay_o_q;
	assign out_ch.entry_usable   = usable_o_q;
	assign out_ch.entry_hits     = hits_o_q;
	assign out_ch.removed_count  = removed_o_q;
	assign out_ch.lru_replaced   = replaced_o_q;
	assign out_ch.occupancy      = CAP_W'(occ_q);
	assign out_ch.hit_total      = hit_tot_q;
	assign out_ch.miss_total     = miss_tot_q;
	assign out_ch.eviction_total = evict_tot_q;
	assign out_ch.insert_total   = ins_tot_q;

`ifndef SYNTHESIS
	// The entry count never exceeds the table size.
	a_occ_bound: assert property (@(posedge clk) disable iff (!arst_n)
		occ_q <= CNT_W'(SLOT_COUNT)) else $error("occupancy above table size");

	// Between items the entry count agrees with the valid bits.
	a_occ_match: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_IDLE |-> $countones(valid_q) == int'(occ_q))
		else $error("occupancy differs from valid bits");

	// A new result only appears after the finishing step.
	a_out_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_vld_q) |-> $past(state_q == S_FINISH))
		else $error("result raised outside finish");
`endif

endmodule

### design/klc_slot_ram.sv
// Single-port-write, registered-read memory holding the table entries.
module klc_slot_ram
	import klc_pkg::*;
#(
	parameter int unsigned SLOT_COUNT = 256,
	parameter int unsigned IDX_W      = 8
) (
	input  logic             clk,
	input  logic             rd_en,
	input  logic [IDX_W-1:0] rd_addr,
	output entry_t           rd_data,
	input  logic             wr_en,
	input  logic [IDX_W-1:0] wr_addr,
	input  entry_t           wr_data
);

	entry_t mem [SLOT_COUNT];

	// Write port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Read port, registered.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule
